// ===== hdl/wfea_pkg.sv =====
package wfea_pkg;

  // Width of the fixed-size payload fields on the ports
  localparam int FIELD_W = 16;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } wfea_cmd_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_FIT     = 2'd1,
    ST_TABLE_FULL = 2'd2
  } wfea_status_e;

  // Separate write enables for the start and size arrays of the extent table
  typedef struct packed {
    logic start;
    logic size;
  } wfea_we_t;

  // Finished result handed from the sequencer to the output register
  typedef struct packed {
    logic               valid;
    logic [FIELD_W-1:0] addr;
    wfea_status_e       status;
  } wfea_res_t;

endpackage

// ===== hdl/wfea_alu.sv =====
module wfea_alu #(
  parameter int CW = 16,
  parameter int AB = 16
) (
  input  logic [CW-1:0] a_i,
  input  logic [CW-1:0] b_i,
  input  logic          sub_i,
  output logic [CW:0]   sum_o,
  output logic [AB-1:0] sat_o,
  output logic [AB-1:0] wrap_o
);

  localparam logic [CW:0] AMAX = (CW+1)'({AB{1'b1}});

  always_comb begin
    if (sub_i) begin
      sum_o = {1'b0, a_i} - {1'b0, b_i};
    end else begin
      sum_o = {1'b0, a_i} + {1'b0, b_i};
    end
    sat_o  = (sum_o > AMAX) ? {AB{1'b1}} : sum_o[AB-1:0];
    wrap_o = sum_o[AB-1:0];
  end

endmodule

// ===== hdl/wfea_table.sv =====
module wfea_table #(
  parameter int DEPTH = 16,
  parameter int IDX_W = 4,
  parameter int DW    = 16
) (
  input  logic                clk_i,
  input  wfea_pkg::wfea_we_t  we_i,
  input  logic [IDX_W-1:0]    waddr_i,
  input  logic [DW-1:0]       wstart_i,
  input  logic [DW-1:0]       wsize_i,
  input  logic [IDX_W-1:0]    raddr_i,
  output logic [DW-1:0]       rstart_o,
  output logic [DW-1:0]       rsize_o
);

  logic [DW-1:0] start_mem [DEPTH];
  logic [DW-1:0] size_mem  [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i.start) begin
      start_mem[waddr_i] <= wstart_i;
    end
    if (we_i.size) begin
      size_mem[waddr_i] <= wsize_i;
    end
    rstart_o <= start_mem[raddr_i];
    rsize_o  <= size_mem[raddr_i];
  end

endmodule

// ===== hdl/wfea_ctrl.sv =====
module wfea_ctrl #(
  parameter int MAX_EXTENTS = 16,
  parameter int ADDR_BITS   = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [wfea_pkg::FIELD_W-1:0]      cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  wfea_pkg::wfea_cmd_e               in_cmd_i,
  input  logic [wfea_pkg::FIELD_W-1:0]      in_size_i,
  input  logic [wfea_pkg::FIELD_W-1:0]      in_start_i,
  output wfea_pkg::wfea_res_t               res_o,
  input  logic                              res_ready_i
);

  localparam int CW    = (ADDR_BITS > wfea_pkg::FIELD_W) ? ADDR_BITS : wfea_pkg::FIELD_W;
  localparam int IDX_W = $clog2(MAX_EXTENTS);
  localparam int CNT_W = $clog2(MAX_EXTENTS + 1);
  localparam logic [CW-1:0]    AMAX_CW = CW'({ADDR_BITS{1'b1}});
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_EXTENTS);
  // total_size after reset is the all-ones field value, saturated to the address width
  localparam logic [CW-1:0]        RST_EXT  = CW'({wfea_pkg::FIELD_W{1'b1}});
  localparam logic [ADDR_BITS-1:0] RST_SIZE = (RST_EXT > AMAX_CW) ? AMAX_CW[ADDR_BITS-1:0]
                                                                  : RST_EXT[ADDR_BITS-1:0];

  typedef enum logic [13:0] {
    S_INIT     = 14'b00000000000001,
    S_IDLE     = 14'b00000000000010,
    S_SCAN     = 14'b00000000000100,
    S_A_POST   = 14'b00000000001000,
    S_A_TRIM_Z = 14'b00000000010000,
    S_F_CHK_N  = 14'b00000000100000,
    S_F_CHK_P  = 14'b00000001000000,
    S_F_ADD1   = 14'b00000010000000,
    S_F_ADD2   = 14'b00000100000000,
    S_SHDN     = 14'b00001000000000,
    S_SHUP     = 14'b00010000000000,
    S_INS_WR   = 14'b00100000000000,
    S_DONE     = 14'b01000000000000,
    S_SPARE    = 14'b10000000000000
  } state_e;

  state_e                 state_q, state_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  wfea_pkg::wfea_cmd_e    cmd_q, cmd_d;
  logic [CW-1:0]          req_q, req_d;
  logic [ADDR_BITS-1:0]   s_q, s_d;
  logic [CNT_W-1:0]       iss_q, iss_d;
  logic                   pend_vld_q, pend_vld_d;
  logic [CNT_W-1:0]       pend_idx_q, pend_idx_d;
  logic                   hit_q, hit_d;
  logic [CNT_W-1:0]       p_q, p_d;
  logic [ADDR_BITS-1:0]   a_start_q, a_start_d;
  logic [ADDR_BITS-1:0]   a_size_q, a_size_d;
  logic [ADDR_BITS-1:0]   b_start_q, b_start_d;
  logic [ADDR_BITS-1:0]   b_size_q, b_size_d;
  logic                   mnext_q, mnext_d;
  logic                   mprev_q, mprev_d;
  logic [ADDR_BITS-1:0]   acc_q, acc_d;
  wfea_pkg::wfea_status_e status_q, status_d;
  logic [ADDR_BITS-1:0]   addr_q, addr_d;

  wfea_pkg::wfea_we_t     we;
  logic [IDX_W-1:0]       waddr, raddr;
  logic [ADDR_BITS-1:0]   wstart, wsize, rstart, rsize;
  logic                   issue;

  logic [CW-1:0]          alu_a, alu_b;
  logic                   alu_sub;
  logic [CW:0]            alu_sum;
  logic [ADDR_BITS-1:0]   alu_sat, alu_wrap;

  logic [CW-1:0]          in_size_ext, cfg_ext;
  logic [ADDR_BITS-1:0]   cfg_sat;

  wfea_alu #(
    .CW (CW),
    .AB (ADDR_BITS)
  ) u_alu (
    .a_i    (alu_a),
    .b_i    (alu_b),
    .sub_i  (alu_sub),
    .sum_o  (alu_sum),
    .sat_o  (alu_sat),
    .wrap_o (alu_wrap)
  );

  wfea_table #(
    .DEPTH (MAX_EXTENTS),
    .IDX_W (IDX_W),
    .DW    (ADDR_BITS)
  ) u_table (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (waddr),
    .wstart_i (wstart),
    .wsize_i  (wsize),
    .raddr_i  (raddr),
    .rstart_o (rstart),
    .rsize_o  (rsize)
  );

  assign in_size_ext = CW'(in_size_i);
  assign cfg_ext     = CW'(cfg_wdata_i);
  assign cfg_sat     = (cfg_ext > AMAX_CW) ? {ADDR_BITS{1'b1}} : ADDR_BITS'(cfg_wdata_i);

  assign in_ready_o   = (state_q == S_IDLE) && !cfg_we_i;
  assign res_o.valid  = (state_q == S_DONE);
  assign res_o.addr   = wfea_pkg::FIELD_W'(addr_q);
  assign res_o.status = status_q;

  // Operand select for the shared adder
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state_q)
      S_F_CHK_N: begin
        alu_a = CW'(s_q);
        alu_b = req_q;
      end
      S_F_CHK_P: begin
        alu_a = CW'(a_start_q);
        alu_b = CW'(a_size_q);
      end
      S_F_ADD1: begin
        if (mnext_q) begin
          alu_a = req_q;
          alu_b = CW'(b_size_q);
        end else begin
          alu_a = CW'(a_size_q);
          alu_b = req_q;
        end
      end
      S_F_ADD2: begin
        alu_a = CW'(a_size_q);
        alu_b = CW'(acc_q);
      end
      S_A_POST: begin
        alu_a = CW'(a_start_q);
        alu_b = req_q;
      end
      S_A_TRIM_Z: begin
        alu_a   = CW'(a_size_q);
        alu_b   = req_q;
        alu_sub = 1'b1;
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_d      = cmd_q;
    req_d      = req_q;
    s_d        = s_q;
    iss_d      = iss_q;
    pend_vld_d = 1'b0;
    pend_idx_d = pend_idx_q;
    hit_d      = hit_q;
    p_d        = p_q;
    a_start_d  = a_start_q;
    a_size_d   = a_size_q;
    b_start_d  = b_start_q;
    b_size_d   = b_size_q;
    mnext_d    = mnext_q;
    mprev_d    = mprev_q;
    acc_d      = acc_q;
    status_d   = status_q;
    addr_d     = addr_q;
    we         = '0;
    waddr      = '0;
    wstart     = '0;
    wsize      = '0;
    raddr      = '0;
    issue      = 1'b0;

    unique case (state_q)
      S_INIT: begin
        we      = '{start: 1'b1, size: 1'b1};
        wsize   = RST_SIZE;
        cnt_d   = CNT_W'(1);
        state_d = S_IDLE;
      end

      S_IDLE: begin
        if (in_valid_i && !cfg_we_i) begin
          cmd_d    = in_cmd_i;
          status_d = wfea_pkg::ST_OK;
          addr_d   = '0;
          s_d      = ADDR_BITS'(in_start_i);
          iss_d    = '0;
          hit_d    = 1'b0;
          p_d      = '0;
          if (in_cmd_i == wfea_pkg::CMD_ALLOC) begin
            req_d   = in_size_ext;
            state_d = S_SCAN;
          end else begin
            req_d   = (in_size_ext > AMAX_CW) ? AMAX_CW : in_size_ext;
            // zero-size free leaves the table alone
            state_d = (in_size_i == '0) ? S_DONE : S_SCAN;
          end
        end
      end

      S_SCAN: begin
        issue = (iss_q < cnt_q) && !((cmd_q == wfea_pkg::CMD_FREE) && hit_q);
        raddr = IDX_W'(iss_q);
        if (pend_vld_q) begin
          if (cmd_q == wfea_pkg::CMD_ALLOC) begin
            if ((CW'(rsize) >= req_q) && (!hit_q || (rsize > a_size_q))) begin
              hit_d     = 1'b1;
              p_d       = pend_idx_q;
              a_start_d = rstart;
              a_size_d  = rsize;
            end
          end else if (!hit_q) begin
            if (rstart < s_q) begin
              a_start_d = rstart;
              a_size_d  = rsize;
              p_d       = pend_idx_q + 1'b1;
            end else begin
              hit_d     = 1'b1;
              p_d       = pend_idx_q;
              b_start_d = rstart;
              b_size_d  = rsize;
            end
          end
        end
        if (issue) begin
          iss_d      = iss_q + 1'b1;
          pend_idx_d = iss_q;
          pend_vld_d = 1'b1;
        end else if (!pend_vld_q) begin
          state_d = (cmd_q == wfea_pkg::CMD_ALLOC) ? S_A_POST : S_F_CHK_N;
        end
      end

      S_A_POST: begin
        if (!hit_q) begin
          status_d = wfea_pkg::ST_NO_FIT;
          state_d  = S_DONE;
        end else begin
          addr_d = a_start_q;
          if (CW'(a_size_q) == req_q) begin
            iss_d   = p_q + 1'b1;
            state_d = S_SHDN;
          end else begin
            we      = '{start: 1'b1, size: 1'b0};
            waddr   = IDX_W'(p_q);
            wstart  = alu_wrap;
            state_d = S_A_TRIM_Z;
          end
        end
      end

      S_A_TRIM_Z: begin
        we      = '{start: 1'b0, size: 1'b1};
        waddr   = IDX_W'(p_q);
        wsize   = alu_wrap;
        state_d = S_DONE;
      end

      S_F_CHK_N: begin
        // adjacency on the unwrapped sum
        mnext_d = hit_q && (alu_sum == (CW+1)'(b_start_q));
        state_d = S_F_CHK_P;
      end

      S_F_CHK_P: begin
        mprev_d = (p_q != '0) && (alu_sum == (CW+1)'(s_q));
        state_d = S_F_ADD1;
      end

      S_F_ADD1: begin
        if (mnext_q && mprev_q) begin
          acc_d   = alu_sat;
          state_d = S_F_ADD2;
        end else if (mnext_q) begin
          we      = '{start: 1'b1, size: 1'b1};
          waddr   = IDX_W'(p_q);
          wstart  = s_q;
          wsize   = alu_sat;
          state_d = S_DONE;
        end else if (mprev_q) begin
          we      = '{start: 1'b0, size: 1'b1};
          waddr   = IDX_W'(p_q - 1'b1);
          wsize   = alu_sat;
          state_d = S_DONE;
        end else if (cnt_q >= MAX_CNT) begin
          status_d = wfea_pkg::ST_TABLE_FULL;
          state_d  = S_DONE;
        end else begin
          iss_d   = cnt_q;
          state_d = S_SHUP;
        end
      end

      S_F_ADD2: begin
        we      = '{start: 1'b0, size: 1'b1};
        waddr   = IDX_W'(p_q - 1'b1);
        wsize   = alu_sat;
        iss_d   = p_q + 1'b1;
        state_d = S_SHDN;
      end

      // close the gap at p_q: entry j moves to j-1
      S_SHDN: begin
        issue = iss_q < cnt_q;
        raddr = IDX_W'(iss_q);
        if (pend_vld_q) begin
          we     = '{start: 1'b1, size: 1'b1};
          waddr  = IDX_W'(pend_idx_q - 1'b1);
          wstart = rstart;
          wsize  = rsize;
        end
        if (issue) begin
          iss_d      = iss_q + 1'b1;
          pend_idx_d = iss_q;
          pend_vld_d = 1'b1;
        end else if (!pend_vld_q) begin
          cnt_d   = cnt_q - 1'b1;
          state_d = S_DONE;
        end
      end

      // open a slot at p_q: entry i-1 moves to i, top down
      S_SHUP: begin
        issue = iss_q > p_q;
        raddr = IDX_W'(iss_q - 1'b1);
        if (pend_vld_q) begin
          we     = '{start: 1'b1, size: 1'b1};
          waddr  = IDX_W'(pend_idx_q);
          wstart = rstart;
          wsize  = rsize;
        end
        if (issue) begin
          iss_d      = iss_q - 1'b1;
          pend_idx_d = iss_q;
          pend_vld_d = 1'b1;
        end else if (!pend_vld_q) begin
          state_d = S_INS_WR;
        end
      end

      S_INS_WR: begin
        we      = '{start: 1'b1, size: 1'b1};
        waddr   = IDX_W'(p_q);
        wstart  = s_q;
        wsize   = req_q[ADDR_BITS-1:0];
        cnt_d   = cnt_q + 1'b1;
        state_d = S_DONE;
      end

      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // table reload; owns the write port
    if (cfg_we_i) begin
      we      = '{start: 1'b1, size: 1'b1};
      waddr   = '0;
      wstart  = '0;
      wsize   = cfg_sat;
      cnt_d   = (cfg_wdata_i != '0) ? CNT_W'(1) : '0;
      state_d = S_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_INIT;
      cnt_q      <= '0;
      pend_vld_q <= 1'b0;
      status_q   <= wfea_pkg::ST_OK;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      pend_vld_q <= pend_vld_d;
      status_q   <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    req_q      <= req_d;
    s_q        <= s_d;
    iss_q      <= iss_d;
    pend_idx_q <= pend_idx_d;
    hit_q      <= hit_d;
    p_q        <= p_d;
    a_start_q  <= a_start_d;
    a_size_q   <= a_size_d;
    b_start_q  <= b_start_d;
    b_size_q   <= b_size_d;
    mnext_q    <= mnext_d;
    mprev_q    <= mprev_d;
    acc_q      <= acc_d;
    addr_q     <= addr_d;
  end

endmodule

// ===== hdl/worst_fit_extent_allocator_unit.sv =====
// Worst-fit extent allocator with coalescing of freed extents.
// Slave stream: one transaction is one command. tuser[0] selects allocate (0)
// or free (1); tdata carries request_size and block_start.
// Master stream: one result per command, alloc_address in tdata and the
// status code (ok, no fit, table full) in tuser.
// Config: cfg_we_i with cfg_wdata_i reloads the table with the single extent
// (0, total_size); total_size of zero leaves it empty. Write only when idle.
// Timing: an allocate scans all n stored extents; a free scans until it finds
// its slot p. An exact fit that removes entry p, an insert, or a merge of
// both sides then shifts the entries above the slot. A shift moves one table
// entry per cycle.
// One command is in flight at a time; s_axis_tready is low while it runs.
// A finished result sits in the output register, so the next command is
// taken while the receiver stalls; a second result then waits in the
// sequencer until the register frees up.
// Reset: the table holds (0, 65535), saturated to the address width; the
// init state writes that entry after reset and then the block is ready.
module worst_fit_extent_allocator_unit #(
  parameter int MAX_EXTENTS = 16,
  parameter int ADDR_BITS   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,    // total_size
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] request_size, [31:16] block_start
  input  logic [0:0]  s_axis_tuser,   // [0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] alloc_address
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  wfea_pkg::wfea_res_t    res;
  logic                   res_ready;
  logic                   out_vld_q;
  logic [15:0]            out_addr_q;
  wfea_pkg::wfea_status_e out_status_q;

  wfea_ctrl #(
    .MAX_EXTENTS (MAX_EXTENTS),
    .ADDR_BITS   (ADDR_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_cmd_i    (wfea_pkg::wfea_cmd_e'(s_axis_tuser[0])),
    .in_size_i   (s_axis_tdata[15:0]),
    .in_start_i  (s_axis_tdata[31:16]),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  assign res_ready = !out_vld_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_ready) begin
      out_vld_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid && res_ready) begin
      out_addr_q   <= res.addr;
      out_status_q <= res.status;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_addr_q;
  assign m_axis_tuser  = out_status_q;

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while a command is in flight");

  a_fail_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != wfea_pkg::ST_OK) |-> m_axis_tdata == '0)
    else $error("failed command returned a nonzero address");

  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> s_axis_tready || cfg_we_i)
    else $error("not ready after table reload");

  a_res_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid && !res_ready && !cfg_we_i |=> res.valid && $stable(res.addr))
    else $error("pending result lost while output register full");
`endif

endmodule

// ===== test/wfea_checker.sv =====
module wfea_checker
  import wfea_pkg::*;
#(
  parameter int MAX_EXTENTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  input  logic [0:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,
  input  logic [1:0]  m_axis_tuser,
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o,
  output int          no_fit_o,
  output int          table_full_o
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [15:0]  addr;
    wfea_status_e status;
  } alloc_result_t;

  // Free-extent table mirror, ascending base order
  logic [15:0] extent_base[MAX_EXTENTS];
  logic [15:0] extent_len[MAX_EXTENTS];
  int          extent_cnt;

  alloc_result_t result_q[$];

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("%0t ns: result %0d: %s got %h, predicted %h", $time, checked_o, what, got,
             want);
    fail_count_o = fail_count_o + 1;
  endtask

  function automatic logic [15:0] sum_sat(logic [15:0] a, logic [15:0] b);
    logic [16:0] s;
    s = 17'(a) + 17'(b);
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  function automatic void reload_extents(logic [15:0] total);
    for (int i = 0; i < MAX_EXTENTS; i++) begin
      extent_base[i] = '0;
      extent_len[i]  = '0;
    end
    extent_cnt = 0;
    if (total != 0) begin
      extent_len[0] = total;
      extent_cnt = 1;
    end
  endfunction

  function automatic void drop_extent(int p);
    for (int i = p; i + 1 < extent_cnt; i++) begin
      extent_base[i] = extent_base[i+1];
      extent_len[i]  = extent_len[i+1];
    end
    extent_cnt--;
  endfunction

  function automatic wfea_status_e alloc_worst_fit(logic [15:0] req, output logic [15:0] addr);
    int best;
    bit found;
    best  = 0;
    found = 1'b0;
    addr  = '0;
    for (int i = 0; i < extent_cnt; i++) begin
      if (extent_len[i] >= req && (!found || extent_len[i] > extent_len[best])) begin
        best  = i;
        found = 1'b1;
      end
    end
    if (!found) return ST_NO_FIT;
    addr = extent_base[best];
    if (extent_len[best] == req) begin
      drop_extent(best);
    end else begin
      extent_base[best] = extent_base[best] + req;  // wraps past the top
      extent_len[best]  = extent_len[best] - req;
    end
    return ST_OK;
  endfunction

  function automatic wfea_status_e free_and_merge(logic [15:0] base, logic [15:0] len);
    int p;
    bit join_next, join_prev;
    if (len == 0) return ST_OK;
    p = 0;
    while (p < extent_cnt && extent_base[p] < base) p++;
    join_next = 1'b0;
    join_prev = 1'b0;
    // adjacency uses the unwrapped end address
    if (p < extent_cnt)
      join_next = (17'(base) + 17'(len)) == 17'(extent_base[p]);
    if (p > 0)
      join_prev = (17'(extent_base[p-1]) + 17'(extent_len[p-1])) == 17'(base);
    if (join_next && join_prev) begin
      extent_len[p-1] = sum_sat(extent_len[p-1], sum_sat(len, extent_len[p]));
      drop_extent(p);
    end else if (join_next) begin
      extent_base[p] = base;
      extent_len[p]  = sum_sat(len, extent_len[p]);
    end else if (join_prev) begin
      extent_len[p-1] = sum_sat(extent_len[p-1], len);
    end else begin
      if (extent_cnt >= MAX_EXTENTS) return ST_TABLE_FULL;
      for (int i = extent_cnt; i > p; i--) begin
        extent_base[i] = extent_base[i-1];
        extent_len[i]  = extent_len[i-1];
      end
      extent_base[p] = base;
      extent_len[p]  = len;
      extent_cnt++;
    end
    return ST_OK;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    alloc_result_t want;
    alloc_result_t got_pred;
    if (!rst_ni) begin
      reload_extents(16'hFFFF);
      result_q.delete();
      pending_o = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        checked_o = checked_o + 1;
        if (result_q.size() == 0) begin
          report_mismatch("unexpected transaction, alloc_address", m_axis_tdata, '0);
        end else begin
          want = result_q.pop_front();
          if (m_axis_tdata !== want.addr)
            report_mismatch("alloc_address", m_axis_tdata, want.addr);
          if (m_axis_tuser !== want.status)
            report_mismatch("status", 16'(m_axis_tuser), 16'(want.status));
        end
      end
      if (cfg_we_i) reload_extents(cfg_wdata_i);
      if (s_axis_tvalid && s_axis_tready) begin
        got_pred.addr = '0;
        if (wfea_cmd_e'(s_axis_tuser[0]) == CMD_ALLOC)
          got_pred.status = alloc_worst_fit(s_axis_tdata[15:0], got_pred.addr);
        else
          got_pred.status = free_and_merge(s_axis_tdata[31:16], s_axis_tdata[15:0]);
        if (got_pred.status == ST_NO_FIT) no_fit_o = no_fit_o + 1;
        if (got_pred.status == ST_TABLE_FULL) table_full_o = table_full_o + 1;
        result_q.push_back(got_pred);
      end
      pending_o = result_q.size();
    end
  end

endmodule

// ===== test/tb_worst_fit_extent_allocator_unit.sv =====
module tb_worst_fit_extent_allocator_unit;

  timeunit 1ns;
  timeprecision 1ps;

  import wfea_pkg::*;

  localparam int MAX_EXTENTS    = 16;
  localparam int SETTLE_CYCLES  = 2 * MAX_EXTENTS + 8;
  localparam int STALL_LIMIT    = 3000;
  localparam int NUM_PHASES     = 8;
  localparam int ITEMS_PER_PHASE = 228;

  typedef struct packed {
    logic [15:0] base;
    logic [15:0] len;
  } extent_t;

  typedef struct packed {
    wfea_cmd_e   cmd;
    logic [15:0] len;
  } issued_cmd_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic [0:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  int fail_count, pending, checked, no_fit_seen, full_seen;
  int send_idle_pct, recv_stall_pct;
  int n_sent, n_cfg, quiet_cycles;

  extent_t     live_q[$];   // regions handed out and not yet freed
  issued_cmd_t issued_q[$];

  worst_fit_extent_allocator_unit #(
    .MAX_EXTENTS(MAX_EXTENTS),
    .ADDR_BITS  (16)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  wfea_checker #(
    .MAX_EXTENTS(MAX_EXTENTS)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .no_fit_o     (no_fit_seen),
    .table_full_o (full_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Track granted regions so that most frees hand back real allocations
  always @(posedge clk_i) begin
    issued_cmd_t done;
    if (m_axis_tvalid && m_axis_tready && issued_q.size() != 0) begin
      done = issued_q.pop_front();
      if (done.cmd == CMD_ALLOC && m_axis_tuser == ST_OK && done.len != 0)
        live_q.push_back('{base: m_axis_tdata, len: done.len});
    end
    if (s_axis_tvalid && s_axis_tready)
      issued_q.push_back('{cmd: wfea_cmd_e'(s_axis_tuser[0]), len: s_axis_tdata[15:0]});
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        cfg_we_i)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t ns: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Entered and left at a falling edge; tvalid stays up between back-to-back commands
  task automatic send_cmd(input wfea_cmd_e cmd, input logic [15:0] len,
                          input logic [15:0] base);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {base, len};
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    n_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_total(input logic [15:0] total);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= total;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    live_q.delete();
    n_cfg++;
  endtask

  task automatic send_random(input int span);
    int roll, idx, lim;
    extent_t blk;
    logic [15:0] len;
    lim  = (span / 16 > 1) ? span / 16 : 1;
    roll = $urandom_range(0, 99);
    if (roll < 45) begin
      case ($urandom_range(0, 19))
        0:       len = '0;
        1:       len = 16'($urandom);
        2:       len = 16'(span);
        default: len = 16'($urandom_range(1, lim));
      endcase
      send_cmd(CMD_ALLOC, len, 16'($urandom));
    end else if (roll < 88 && live_q.size() != 0) begin
      idx = $urandom_range(0, live_q.size() - 1);
      blk = live_q[idx];
      live_q.delete(idx);
      send_cmd(CMD_FREE, blk.len, blk.base);
    end else begin
      send_cmd(wfea_cmd_e'($urandom_range(0, 1)), 16'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    logic [15:0] totals[NUM_PHASES];
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = CMD_ALLOC;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    totals = '{16'hFFFF, 16'd1, 16'd2048, 16'hFFFF, 16'd64, 16'd40000,
               16'($urandom_range(1, 65535)), 16'd16};
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset table (0, 65535)
    send_cmd(CMD_ALLOC, 16'd0, 16'd0);         // zero-size: largest extent, no change
    send_cmd(CMD_ALLOC, 16'd100, 16'hFFFF);
    send_cmd(CMD_ALLOC, 16'hFFFF, 16'd0);      // no fit
    send_cmd(CMD_FREE, 16'd0, 16'd7);          // zero-size free ignored
    send_cmd(CMD_FREE, 16'd100, 16'd0);        // merges with the following extent
    send_cmd(CMD_ALLOC, 16'hFFFF, 16'd0);      // exact fit empties the table
    send_cmd(CMD_ALLOC, 16'd0, 16'd0);         // empty table
    send_cmd(CMD_FREE, 16'hFFFF, 16'hFFFF);
    send_cmd(CMD_ALLOC, 16'd2, 16'd0);         // trim wraps the base past the top
    drain();

    write_total(16'd0);
    send_cmd(CMD_ALLOC, 16'd5, 16'd0);
    send_cmd(CMD_FREE, 16'd3, 16'd10);
    send_cmd(CMD_FREE, 16'd2, 16'd10);         // same base goes in front
    for (int k = 0; k < MAX_EXTENTS - 2; k++)
      send_cmd(CMD_FREE, 16'd1, 16'(20 + 2 * k));
    send_cmd(CMD_FREE, 16'd1, 16'd100);        // full, nothing to merge
    send_cmd(CMD_FREE, 16'd7, 16'd13);         // full, merges both sides
    drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_total(totals[ph]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      repeat (ITEMS_PER_PHASE) send_random(int'(totals[ph]));
      drain();
    end

    $display("Sent %0d commands over %0d total_size loads and four flow-control mixes.",
             n_sent, n_cfg);
    $display("Checked %0d results: %0d no_fit, %0d table_full.", checked, no_fit_seen,
             full_seen);
    if (fail_count == 0 && pending == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/wfea_pkg.sv
hdl/wfea_alu.sv
hdl/wfea_table.sv
hdl/wfea_ctrl.sv
hdl/worst_fit_extent_allocator_unit.sv
test/wfea_checker.sv
test/tb_worst_fit_extent_allocator_unit.sv
